// ----- src/b14u_pkg.sv -----
// Types and constants shared by the 14-bit to UTF-16 encoder.
// No dependencies.
`default_nettype none

package b14u_pkg;

  localparam logic [15:0] WORD_BASE    = 16'h4E00;
  localparam logic [15:0] MARKER_WORD  = 16'hFEFF;
  localparam logic [15:0] TRAILER_BASE = 16'h3D00;
  localparam logic [2:0]  LAST_PHASE   = 3'd6;
  localparam int          BURST_DEPTH  = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        last_word;
  } out_beat_t;

  // Words raised by one input byte, entry 0 goes out first.
  typedef struct packed {
    out_beat_t [BURST_DEPTH-1:0] words;
    logic [1:0]                  count;
  } burst_t;

  // Bits held over after a given byte phase: (8 * phase) mod 14.
  function automatic logic [3:0] held_bits(input logic [2:0] phase);
    logic [3:0] held;
    case (phase)
      3'd1:    held = 4'd8;
      3'd2:    held = 4'd2;
      3'd3:    held = 4'd10;
      3'd4:    held = 4'd4;
      3'd5:    held = 4'd12;
      3'd6:    held = 4'd6;
      default: held = 4'd0;
    endcase
    return held;
  endfunction

endpackage

`default_nettype wire

// ----- src/b14u_pack.sv -----
// Bit packer: holds the message state and works out the words for one byte.
// Depends on b14u_pkg.
`default_nettype none

module b14u_pack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire b14u_pkg::in_beat_t beat,
  output b14u_pkg::burst_t       burst
);

  logic [11:0] pending_bits;
  logic [2:0]  byte_phase;
  logic        marker_sent;

  logic [2:0]  phase_eff;
  logic [2:0]  phase_next;
  logic [19:0] acc;
  logic [4:0]  total;
  logic        has_word;
  logic [3:0]  rest;
  logic [13:0] data_val;
  logic [11:0] kept;
  logic [13:0] padded;
  logic [1:0]  n;

  always_comb begin
    phase_eff  = (byte_phase == 3'd7) ? 3'd0 : byte_phase;
    phase_next = (phase_eff == b14u_pkg::LAST_PHASE) ? 3'd0 : phase_eff + 3'd1;
    acc        = {pending_bits, beat.data_byte};
    total      = {1'b0, b14u_pkg::held_bits(phase_eff)} + 5'd8;
    has_word   = (total >= 5'd14);
    rest       = has_word ? 4'(total - 5'd14) : total[3:0];
    data_val   = 14'(acc >> rest);
    kept       = 12'(acc & ((20'd1 << rest) - 20'd1));
    // left-align the leftover bits in a 14-bit field
    padded     = 14'({kept, 14'd0} >> rest);
  end

  always_comb begin
    burst = '0;
    n     = 2'd0;
    if (!marker_sent) begin
      burst.words[n] = '{out_word: b14u_pkg::MARKER_WORD, last_word: 1'b0};
      n = n + 2'd1;
    end
    if (has_word) begin
      burst.words[n] = '{out_word: b14u_pkg::WORD_BASE + {2'b00, data_val},
                         last_word: 1'b0};
      n = n + 2'd1;
    end
    if (beat.last_byte) begin
      if (rest != 4'd0) begin
        burst.words[n] = '{out_word: b14u_pkg::WORD_BASE + {2'b00, padded},
                           last_word: 1'b0};
        n = n + 2'd1;
        burst.words[n] = '{out_word: b14u_pkg::TRAILER_BASE + {13'd0, phase_next},
                           last_word: 1'b1};
        n = n + 2'd1;
      end else begin
        // whole group: the completed word closes the message
        burst.words[n - 2'd1].last_word = 1'b1;
      end
    end
    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= '0;
      byte_phase   <= '0;
      marker_sent  <= 1'b0;
    end else if (accept) begin
      if (beat.last_byte) begin
        pending_bits <= '0;
        byte_phase   <= '0;
        marker_sent  <= 1'b0;
      end else begin
        pending_bits <= kept;
        byte_phase   <= phase_next;
        marker_sent  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/b14u_outq.sv -----
// Result buffer: holds up to three words and sends them one beat a cycle while out_ready is high.
// Depends on b14u_pkg.
`default_nettype none

module b14u_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire b14u_pkg::burst_t  burst,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output b14u_pkg::out_beat_t    out_data
);

  b14u_pkg::out_beat_t [b14u_pkg::BURST_DEPTH-1:0] words;
  logic [1:0] count;
  logic       take;

  assign out_valid = (count != 2'd0);
  assign out_data  = words[0];
  assign take      = out_valid && out_ready;
  // new burst only into a buffer that is empty or empties this cycle
  assign can_load  = (count == 2'd0) || ((count == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= burst.words;
    end else if (take) begin
      words[0] <= words[1];
      words[1] <= words[2];
    end
  end

endmodule

`default_nettype wire

// ----- src/bits14_to_utf16_encoder_top.sv -----
// Top level of the 14-bit to UTF-16 encoder: packer and result buffer.
// Depends on b14u_pkg, b14u_pack, b14u_outq.
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_ready  | in_data  (data_byte, last_byte)
//  out     | out       | out_valid / out_ready| out_data (out_word, last_word)
//
// One byte is taken per cycle while in_ready is high; its first word, if any, reaches out_data the next cycle.
// A byte raising two or three words (marker, final word, trailer) holds
// in_ready low until the buffer is down to its last word.
// Inside a message at most one word per byte, so a free-running sink sees 1 byte/cycle.
// rst clears the message state and empties the buffer; out_ready low stalls input
// as soon as the buffer holds a word that cannot leave.
`default_nettype none

module bits14_to_utf16_encoder_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire b14u_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output b14u_pkg::out_beat_t    out_data
);

  b14u_pkg::burst_t burst;
  logic             accept;
  logic             can_load;

  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  b14u_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (in_data),
    .burst  (burst)
  );

  b14u_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_load_over_stall: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !out_ready && in_ready))
    else $error("input taken while a stalled word is held");

  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last_byte) |=> out_valid)
    else $error("closing byte raised no word");

  a_last_not_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_word) |-> (out_data.out_word != b14u_pkg::MARKER_WORD))
    else $error("marker flagged as final word");
`endif

endmodule

`default_nettype wire
